// ===== rtl/core/smooth_follow_crop_window_unit_macros.svh =====
// Assertion macros for the smooth follow crop window unit.
`ifndef SMOOTH_FOLLOW_CROP_WINDOW_UNIT_MACROS_SVH
`define SMOOTH_FOLLOW_CROP_WINDOW_UNIT_MACROS_SVH

// cond holds in a cycle -> conseq holds in that same cycle
`define SFCW_ASSERT_NOW(name, cond, conseq, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (conseq)) \
		else $error(msg);

// cond holds in a cycle -> conseq holds in the next cycle
`define SFCW_ASSERT_NEXT(name, cond, conseq, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (conseq)) \
		else $error(msg);

`endif

// ===== rtl/core/sfcw_pkg.sv =====
// Types, constants and arithmetic helpers of the smooth follow crop window unit.
package sfcw_pkg;

	localparam int FRAC_BITS  = 8;
	localparam int COORD_BITS = 12;
	localparam int POS_W      = COORD_BITS + 2 + FRAC_BITS;
	localparam int VEL_W      = FRAC_BITS + 8;
	localparam int BOX_W      = 14;
	localparam int DW         = 40;
	localparam int MW         = DW / 2;
	localparam int SQW        = DW / 2;
	localparam int DVW        = 21;
	localparam int MCW        = $clog2(MW);
	localparam int DCW        = $clog2(DW);
	localparam int SCW        = $clog2(SQW);

	localparam int SPRING_DIV = 50;
	localparam int DRIFT_DIV  = 100;
	localparam int ACC_LIM    = 3 << (FRAC_BITS - 1);
	localparam int SPD_LIM    = 20 << FRAC_BITS;

	typedef logic signed [DW-1:0]    dw_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [VEL_W-1:0] vel_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	localparam dw_t POS_MAX = DW'((1 << (POS_W - 1)) - 1);
	localparam dw_t POS_MIN = -POS_MAX - dw_t'(1);
	localparam dw_t VEL_MAX = DW'((1 << (VEL_W - 1)) - 1);
	localparam dw_t VEL_MIN = -VEL_MAX - dw_t'(1);

	localparam pos_t CAM_X_RST = POS_W'(2560 << (FRAC_BITS - 1));
	localparam pos_t CAM_Y_RST = POS_W'((205 + 1085) << (FRAC_BITS - 1));

	function automatic dw_t abs_dw(dw_t x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic dw_t apply_sign(logic neg, logic [DW-1:0] mag);
		dw_t m;
		m = dw_t'(mag);
		return neg ? -m : m;
	endfunction

	// round half away from zero, divide by four
	function automatic dw_t rnd_q4(dw_t n);
		dw_t q;
		q = (abs_dw(n) + dw_t'(2)) >>> 2;
		return (n < 0) ? -q : q;
	endfunction

	function automatic dw_t clamp_dw(dw_t v, dw_t lo, dw_t hi);
		dw_t r;
		r = v;
		if (r > hi) r = hi;
		if (r < lo) r = lo;
		return r;
	endfunction

	function automatic pos_t sat_pos(dw_t x);
		dw_t r;
		r = clamp_dw(x, POS_MIN, POS_MAX);
		return POS_W'(r);
	endfunction

	function automatic vel_t sat_vel(dw_t x);
		dw_t r;
		r = clamp_dw(x, VEL_MIN, VEL_MAX);
		return VEL_W'(r);
	endfunction

endpackage

// ===== rtl/core/sfcw_if.sv =====
// Stream interfaces: track item input and crop window result output.
interface sfcw_track_if import sfcw_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    track_present;
	logic signed [BOX_W-1:0] box_xmin;
	logic signed [BOX_W-1:0] box_ymin;
	logic signed [BOX_W-1:0] box_xmax;
	logic signed [BOX_W-1:0] box_ymax;
	logic                    ball_seen;

	modport source(output valid, track_present, box_xmin, box_ymin, box_xmax, box_ymax,
		ball_seen, input ready);
	modport sink(input valid, track_present, box_xmin, box_ymin, box_xmax, box_ymax,
		ball_seen, output ready);
endinterface

interface sfcw_window_if import sfcw_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] window_left;
	logic [COORD_BITS-1:0] window_top;

	modport source(output valid, window_left, window_top, input ready);
	modport sink(input valid, window_left, window_top, output ready);
endinterface

// ===== rtl/core/sfcw_mul.sv =====
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
module sfcw_mul import sfcw_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [MW-1:0]   a,
	input  logic [MW-1:0]   b,
	output logic [2*MW-1:0] prod,
	output unit_stat_t      stat
);

	logic [MW-1:0]   a_q;
	logic [2*MW-1:0] p_q;
	logic [MCW-1:0]  cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [MW:0]     sum;

	always_comb begin
		if (p_q[0]) begin
			sum = {1'b0, p_q[2*MW-1:MW]} + {1'b0, a_q};
		end else begin
			sum = {1'b0, p_q[2*MW-1:MW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == MCW'(MW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + MCW'(1);
				if (cnt_q == MCW'(MW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{MW{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {sum, p_q[MW-1:1]};
		end
	end

	assign prod = p_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/sfcw_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sfcw_div import sfcw_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  num,
	input  logic [DVW-1:0] den,
	output logic [DW-1:0]  quo,
	output unit_stat_t     stat
);

	logic [DVW-1:0] d_q;
	logic [DVW-1:0] r_q;
	logic [DW-1:0]  q_q;
	logic [DCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW:0]   trial;
	logic           take;

	assign trial = {r_q, q_q[DW-1]};
	assign take  = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DCW'(DW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DCW'(1);
				if (cnt_q == DCW'(DW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q <= den;
			r_q <= '0;
			q_q <= num;
		end else if (busy_q) begin
			if (take) begin
				r_q <= DVW'(trial - {1'b0, d_q});
			end else begin
				r_q <= trial[DVW-1:0];
			end
			q_q <= {q_q[DW-2:0], take};
		end
	end

	assign quo  = q_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/sfcw_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module sfcw_sqrt import sfcw_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  rad,
	output logic [SQW-1:0] root,
	output unit_stat_t     stat
);

	logic [DW-1:0]  v_q;
	logic [SQW:0]   rem_q;
	logic [SQW-1:0] root_q;
	logic [SCW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [SQW+2:0] rem2;
	logic [SQW+2:0] trial;

	assign rem2  = {rem_q, v_q[DW-1 -: 2]};
	assign trial = (SQW+3)'({root_q, 2'b01});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == SCW'(SQW - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + SCW'(1);
				if (cnt_q == SCW'(SQW - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q <= {v_q[DW-3:0], 2'b00};
			if (rem2 >= trial) begin
				rem_q  <= (SQW+1)'(rem2 - trial);
				root_q <= {root_q[SQW-2:0], 1'b1};
			end else begin
				rem_q  <= rem2[SQW:0];
				root_q <= {root_q[SQW-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ===== rtl/core/smooth_follow_crop_window_unit.sv =====
// Smooth follow crop window top level: a spring-damper camera centre follows a
// tracked aim point once per video frame and emits the crop rectangle's left and
// top corner. Positions are signed fixed point with 8 fractional bits. A frame is
// taken on the track channel when the unit is idle; its result transfer goes out
// through an output register, and the aim update and idle count follow. A frame
// keeps the unit busy after its transfer, and also while the result waits for the output
// register: the sequencer steps through shared serial units, a multiplier, a divider and
// a square root; how long it stays busy depends on whether the dead zone holds, whether
// the acceleration and speed caps engage and whether the aim drifts.
// Configuration registers sit on the APB port at byte address 4 * index.
`include "smooth_follow_crop_window_unit_macros.svh"

module smooth_follow_crop_window_unit import sfcw_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sfcw_track_if.sink    track,
	sfcw_window_if.source window,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam logic [2:0] REG_IMAGE_WIDTH    = 3'd0;
	localparam logic [2:0] REG_CROP_WIDTH     = 3'd1;
	localparam logic [2:0] REG_CROP_HEIGHT    = 3'd2;
	localparam logic [2:0] REG_BAND_TOP       = 3'd3;
	localparam logic [2:0] REG_BAND_BOTTOM    = 3'd4;
	localparam logic [2:0] REG_RECENTER_DELAY = 3'd5;

	localparam logic [DW-1:0] ACC_SQ = DW'(ACC_LIM * ACC_LIM);
	localparam logic [DW-1:0] SPD_SQ = DW'(SPD_LIM * SPD_LIM);
	localparam dw_t           OMAX   = DW'((1 << COORD_BITS) - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_DZ, ST_FDX, ST_FDY, ST_MX, ST_MY, ST_CMP, ST_SQ, ST_PX, ST_DX,
		ST_PY, ST_DY, ST_CEND, ST_MOVE, ST_WIN, ST_EMIT, ST_TRK, ST_AIM, ST_ICNT,
		ST_DRX, ST_DRY
	} state_t;

	typedef enum logic {PH_ACC, PH_SPD} phase_t;

	state_t state_q;
	phase_t phase_q;
	logic   issued_q;

	logic [12:0] iw_q, cw_q, ch_q, bb_q;
	logic [11:0] bt_q;
	logic [15:0] rd_q;

	pos_t        cam_x_q, cam_y_q, aim_x_q, aim_y_q;
	pos_t        avx_q, avy_q, pax_q, pay_q;
	vel_t        vel_x_q, vel_y_q;
	logic [15:0] idle_q;

	logic tp_q, ball_q;
	pos_t nx_q, ny_q;

	dw_t            ux_q, uy_q;
	logic [DW-1:0]  m_q, pm_q;
	logic [SQW-1:0] s_q;

	logic           mul_go_q, div_go_q, sq_go_q;
	logic [MW-1:0]  mul_a_q, mul_b_q;
	logic [DW-1:0]  div_n_q, sq_v_q;
	logic [DVW-1:0] div_d_q;
	logic [2*MW-1:0] mul_p;
	logic [DW-1:0]  div_q;
	logic [SQW-1:0] sq_r;
	unit_stat_t     mul_st, div_st, sq_st;

	logic                  out_v_q;
	logic [COORD_BITS-1:0] left_q, top_q;

	dw_t           lo_x, hi_x, lo_y, hi_y, cx, cy;
	dw_t           dx, dy, dwx, dwy;
	logic          dead;
	dw_t           lft, tpv;
	logic [15:0]   idle_n;
	logic [DW-1:0] lim_sq;
	logic [MW-1:0] lim;
	logic          cfg_wr;

	sfcw_mul u_mul (
		.clk, .arst_n, .start(mul_go_q), .a(mul_a_q), .b(mul_b_q),
		.prod(mul_p), .stat(mul_st)
	);

	sfcw_div u_div (
		.clk, .arst_n, .start(div_go_q), .num(div_n_q), .den(div_d_q),
		.quo(div_q), .stat(div_st)
	);

	sfcw_sqrt u_sqrt (
		.clk, .arst_n, .start(sq_go_q), .rad(sq_v_q), .root(sq_r), .stat(sq_st)
	);

	always_comb begin
		lo_x = dw_t'(cw_q) <<< (FRAC_BITS - 1);
		hi_x = (dw_t'(iw_q) <<< FRAC_BITS) - lo_x;
		lo_y = (dw_t'(bt_q) <<< FRAC_BITS) + (dw_t'(ch_q) <<< (FRAC_BITS - 1));
		hi_y = (dw_t'(bb_q) <<< FRAC_BITS) - (dw_t'(ch_q) <<< (FRAC_BITS - 1));
		cx   = dw_t'(iw_q) <<< (FRAC_BITS - 1);
		cy   = (dw_t'(bt_q) + dw_t'(bb_q)) <<< (FRAC_BITS - 1);
		dx   = dw_t'(aim_x_q) - dw_t'(cam_x_q);
		dy   = dw_t'(aim_y_q) - dw_t'(cam_y_q);
		dead = (((abs_dw(dx) <<< 2) + abs_dw(dx)) < (dw_t'(cw_q) <<< FRAC_BITS)) &&
			(((abs_dw(dy) <<< 2) + abs_dw(dy)) < (dw_t'(ch_q) <<< FRAC_BITS));
		dwx  = dw_t'(cam_x_q) - (dw_t'(cw_q) <<< (FRAC_BITS - 1));
		dwy  = dw_t'(cam_y_q) - (dw_t'(ch_q) <<< (FRAC_BITS - 1));

		lft = ux_q;
		if (lft + dw_t'(cw_q) > dw_t'(iw_q)) lft = dw_t'(iw_q) - dw_t'(cw_q);
		lft = clamp_dw(lft, dw_t'(0), OMAX);
		tpv = uy_q;
		if (tpv < dw_t'(bt_q)) tpv = dw_t'(bt_q);
		if (tpv + dw_t'(ch_q) > dw_t'(bb_q)) tpv = dw_t'(bb_q) - dw_t'(ch_q);
		tpv = clamp_dw(tpv, dw_t'(0), OMAX);

		idle_n = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
		lim_sq = (phase_q == PH_SPD) ? SPD_SQ : ACC_SQ;
		lim    = (phase_q == PH_SPD) ? MW'(SPD_LIM) : MW'(ACC_LIM);
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[4:2])
			REG_IMAGE_WIDTH:    prdata = 32'(iw_q);
			REG_CROP_WIDTH:     prdata = 32'(cw_q);
			REG_CROP_HEIGHT:    prdata = 32'(ch_q);
			REG_BAND_TOP:       prdata = 32'(bt_q);
			REG_BAND_BOTTOM:    prdata = 32'(bb_q);
			REG_RECENTER_DELAY: prdata = 32'(rd_q);
			default:            prdata = '0;
		endcase
	end

	assign track.ready    = (state_q == ST_IDLE);
	assign window.valid       = out_v_q;
	assign window.window_left = left_q;
	assign window.window_top  = top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			phase_q  <= PH_ACC;
			issued_q <= 1'b0;
			mul_go_q <= 1'b0;
			div_go_q <= 1'b0;
			sq_go_q  <= 1'b0;
			out_v_q  <= 1'b0;
			iw_q     <= 13'd2560;
			cw_q     <= 13'd1280;
			ch_q     <= 13'd736;
			bt_q     <= 12'd205;
			bb_q     <= 13'd1085;
			rd_q     <= 16'd60;
			cam_x_q  <= CAM_X_RST;
			cam_y_q  <= CAM_Y_RST;
			aim_x_q  <= CAM_X_RST;
			aim_y_q  <= CAM_Y_RST;
			pax_q    <= CAM_X_RST;
			pay_q    <= CAM_Y_RST;
			avx_q    <= '0;
			avy_q    <= '0;
			vel_x_q  <= '0;
			vel_y_q  <= '0;
			idle_q   <= '0;
		end else begin
			mul_go_q <= !issued_q && (state_q inside {ST_MX, ST_MY, ST_PX, ST_PY});
			div_go_q <= !issued_q &&
				(state_q inside {ST_FDX, ST_FDY, ST_DX, ST_DY, ST_DRX, ST_DRY});
			sq_go_q  <= !issued_q && (state_q == ST_SQ);
			// ST_EMIT only leaves once the output register is free or draining
			out_v_q  <= (state_q == ST_EMIT) ? 1'b1 : (out_v_q && !window.ready);

			if (cfg_wr) begin
				case (paddr[4:2])
					REG_IMAGE_WIDTH:    iw_q <= pwdata[12:0];
					REG_CROP_WIDTH:     cw_q <= pwdata[12:0];
					REG_CROP_HEIGHT:    ch_q <= pwdata[12:0];
					REG_BAND_TOP:       bt_q <= pwdata[11:0];
					REG_BAND_BOTTOM:    bb_q <= pwdata[12:0];
					REG_RECENTER_DELAY: rd_q <= pwdata[15:0];
					default: ;
				endcase
			end

			case (state_q)
				ST_IDLE: begin
					if (track.valid) begin
						tp_q   <= track.track_present;
						ball_q <= track.ball_seen;
						nx_q   <= POS_W'((dw_t'(track.box_xmin) + dw_t'(track.box_xmax))
							<<< (FRAC_BITS - 1));
						ny_q   <= POS_W'((dw_t'(track.box_ymin) + dw_t'(track.box_ymax))
							<<< (FRAC_BITS - 1));
						state_q <= ST_DZ;
					end
				end
				ST_DZ: begin
					if (dead) begin
						ux_q    <= rnd_q4((dw_t'(vel_x_q) <<< 1) + dw_t'(vel_x_q));
						uy_q    <= rnd_q4((dw_t'(vel_y_q) <<< 1) + dw_t'(vel_y_q));
						phase_q <= PH_SPD;
						state_q <= ST_MX;
					end else begin
						ux_q <= dx - ((dw_t'(vel_x_q) <<< 4) + (dw_t'(vel_x_q) <<< 3)
							+ dw_t'(vel_x_q));
						uy_q <= dy - ((dw_t'(vel_y_q) <<< 4) + (dw_t'(vel_y_q) <<< 3)
							+ dw_t'(vel_y_q));
						phase_q <= PH_ACC;
						state_q <= ST_FDX;
					end
				end
				ST_FDX, ST_FDY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						div_d_q  <= DVW'(2 * SPRING_DIV);
						if (state_q == ST_FDX) begin
							div_n_q <= DW'((abs_dw(ux_q) <<< 1) + dw_t'(SPRING_DIV));
						end else begin
							div_n_q <= DW'((abs_dw(uy_q) <<< 1) + dw_t'(SPRING_DIV));
						end
					end else if (div_st.done) begin
						issued_q <= 1'b0;
						if (state_q == ST_FDX) begin
							ux_q    <= apply_sign(ux_q < 0, div_q);
							state_q <= ST_FDY;
						end else begin
							uy_q    <= apply_sign(uy_q < 0, div_q);
							state_q <= ST_MX;
						end
					end
				end
				ST_MX, ST_MY, ST_PX, ST_PY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						if (state_q == ST_MX || state_q == ST_PX) begin
							mul_a_q <= MW'(abs_dw(ux_q));
						end else begin
							mul_a_q <= MW'(abs_dw(uy_q));
						end
						case (state_q)
							ST_MX:   mul_b_q <= MW'(abs_dw(ux_q));
							ST_MY:   mul_b_q <= MW'(abs_dw(uy_q));
							default: mul_b_q <= lim;
						endcase
					end else if (mul_st.done) begin
						issued_q <= 1'b0;
						case (state_q)
							ST_MX: begin
								m_q     <= mul_p;
								state_q <= ST_MY;
							end
							ST_MY: begin
								m_q     <= m_q + mul_p;
								state_q <= ST_CMP;
							end
							ST_PX: begin
								pm_q    <= mul_p;
								state_q <= ST_DX;
							end
							default: begin
								pm_q    <= mul_p;
								state_q <= ST_DY;
							end
						endcase
					end
				end
				ST_CMP: begin
					state_q <= (m_q > lim_sq) ? ST_SQ : ST_CEND;
				end
				ST_SQ: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						sq_v_q   <= m_q;
					end else if (sq_st.done) begin
						issued_q <= 1'b0;
						s_q      <= sq_r;
						state_q  <= ST_PX;
					end
				end
				ST_DX, ST_DY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						div_n_q  <= (pm_q << 1) + DW'(s_q);
						div_d_q  <= {s_q, 1'b0};
					end else if (div_st.done) begin
						issued_q <= 1'b0;
						if (state_q == ST_DX) begin
							ux_q    <= apply_sign(ux_q < 0, div_q);
							state_q <= ST_PY;
						end else begin
							uy_q    <= apply_sign(uy_q < 0, div_q);
							state_q <= ST_CEND;
						end
					end
				end
				ST_CEND: begin
					if (phase_q == PH_ACC) begin
						ux_q    <= dw_t'(vel_x_q) + ux_q;
						uy_q    <= dw_t'(vel_y_q) + uy_q;
						phase_q <= PH_SPD;
						state_q <= ST_MX;
					end else begin
						vel_x_q <= sat_vel(ux_q);
						vel_y_q <= sat_vel(uy_q);
						state_q <= ST_MOVE;
					end
				end
				ST_MOVE: begin
					cam_x_q <= sat_pos(clamp_dw(dw_t'(cam_x_q) + dw_t'(vel_x_q), lo_x, hi_x));
					cam_y_q <= sat_pos(clamp_dw(dw_t'(cam_y_q) + dw_t'(vel_y_q), lo_y, hi_y));
					state_q <= ST_WIN;
				end
				ST_WIN: begin
					ux_q    <= (dwx < 0) ? dw_t'(0) : (dwx >>> FRAC_BITS);
					uy_q    <= (dwy < 0) ? dw_t'(0) : (dwy >>> FRAC_BITS);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_v_q || window.ready) begin
						left_q  <= COORD_BITS'(lft);
						top_q   <= COORD_BITS'(tpv);
						state_q <= ST_TRK;
					end
				end
				ST_TRK: begin
					if (tp_q) begin
						avx_q <= sat_pos(rnd_q4(dw_t'(nx_q) - dw_t'(pax_q)
							+ (dw_t'(avx_q) <<< 1) + dw_t'(avx_q)));
						avy_q <= sat_pos(rnd_q4(dw_t'(ny_q) - dw_t'(pay_q)
							+ (dw_t'(avy_q) <<< 1) + dw_t'(avy_q)));
						state_q <= ST_AIM;
					end else begin
						state_q <= ST_ICNT;
					end
				end
				ST_AIM: begin
					pax_q   <= aim_x_q;
					pay_q   <= aim_y_q;
					aim_x_q <= sat_pos(clamp_dw(dw_t'(nx_q) + (dw_t'(avx_q) <<< 1), lo_x, hi_x));
					aim_y_q <= sat_pos(clamp_dw(dw_t'(ny_q) + (dw_t'(avy_q) <<< 1), lo_y, hi_y));
					idle_q  <= '0;
					state_q <= ST_ICNT;
				end
				ST_ICNT: begin
					if (!ball_q) begin
						idle_q  <= idle_n;
						state_q <= (idle_n > rd_q) ? ST_DRX : ST_IDLE;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_DRX, ST_DRY: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
						div_d_q  <= DVW'(2 * DRIFT_DIV);
						if (state_q == ST_DRX) begin
							ux_q    <= cx - dw_t'(aim_x_q);
							div_n_q <= DW'((abs_dw(cx - dw_t'(aim_x_q)) <<< 1)
								+ dw_t'(DRIFT_DIV));
						end else begin
							ux_q    <= cy - dw_t'(aim_y_q);
							div_n_q <= DW'((abs_dw(cy - dw_t'(aim_y_q)) <<< 1)
								+ dw_t'(DRIFT_DIV));
						end
					end else if (div_st.done) begin
						issued_q <= 1'b0;
						if (state_q == ST_DRX) begin
							aim_x_q <= sat_pos(dw_t'(aim_x_q) + apply_sign(ux_q < 0, div_q));
							state_q <= ST_DRY;
						end else begin
							aim_y_q <= sat_pos(dw_t'(aim_y_q) + apply_sign(ux_q < 0, div_q));
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`SFCW_ASSERT_NOW(a_mul_free, mul_go_q, !mul_st.busy, "multiplier restarted while busy")
	`SFCW_ASSERT_NOW(a_div_free, div_go_q, !div_st.busy, "divider restarted while busy")
	`SFCW_ASSERT_NEXT(a_take_busy, track.valid && track.ready, state_q == ST_DZ,
		"accepted frame did not start the camera update")
	`SFCW_ASSERT_NEXT(a_hold_result, out_v_q && !window.ready, out_v_q,
		"pending result dropped")

endmodule

// ===== tb/sv/tb_smooth_follow_crop_window_unit.sv =====
// Self-checking testbench for the smooth follow crop window unit.
module tb_smooth_follow_crop_window_unit;
	import sfcw_pkg::*;

	localparam int  PERIOD     = 12;
	localparam int  DRAIN      = 700;
	localparam longint LIMIT   = 6000000;
	localparam int  N_PHASES   = 6;
	localparam int  PHASE_ITEMS = 285;
	localparam int  EXP_DEPTH  = 16;
	localparam int  N_ROWS     = 20;

	localparam logic [4:0] REG_IMAGE_WIDTH    = 5'd0;
	localparam logic [4:0] REG_CROP_WIDTH     = 5'd4;
	localparam logic [4:0] REG_CROP_HEIGHT    = 5'd8;
	localparam logic [4:0] REG_BAND_TOP       = 5'd12;
	localparam logic [4:0] REG_BAND_BOTTOM    = 5'd16;
	localparam logic [4:0] REG_RECENTER_DELAY = 5'd20;

	typedef struct {
		bit                      present;
		logic signed [BOX_W-1:0] xmin;
		logic signed [BOX_W-1:0] ymin;
		logic signed [BOX_W-1:0] xmax;
		logic signed [BOX_W-1:0] ymax;
		bit                      ball;
	} frame_t;

	typedef struct {
		frame_t                frame;
		bit                    fixed;
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
	} frame_row_t;

	typedef struct {
		logic [COORD_BITS-1:0] left;
		logic [COORD_BITS-1:0] top;
	} window_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	sfcw_track_if  trk_if();
	sfcw_window_if win_if();

	smooth_follow_crop_window_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.track  (trk_if),
		.window (win_if),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready)
	);

	window_t exp_windows[EXP_DEPTH];
	int      exp_wr;
	int      exp_rd;
	int      errors;
	longint  cycles;
	int      snd_idle;
	int      rcv_stall;

	// predictor state and register copy
	longint img_w, crop_w, crop_h, band_t, band_b, delay;
	longint cam_x, cam_y, vel_x, vel_y, aim_x, aim_y;
	longint avel_x, avel_y, paim_x, paim_y;
	longint idle_cnt;

	// stimulus target walk
	longint tgt_x, tgt_y;
	int     no_ball_run;

	initial clk = 1'b0;
	always #(PERIOD / 2) clk = ~clk;

	function automatic longint sat_w(longint x, int bits);
		longint lim;
		lim = longint'(1) << (bits - 1);
		if (x < -lim) return -lim;
		if (x > lim - 1) return lim - 1;
		return x;
	endfunction

	function automatic longint div_round(longint n, longint d);
		longint m, q;
		m = (n < 0) ? -n : n;
		q = (2 * m + d) / (2 * d);
		return (n < 0) ? -q : q;
	endfunction

	function automatic longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v;
	endfunction

	task automatic limit_vector(inout longint x, inout longint y, input longint lim);
		longint m, s;
		m = x * x + y * y;
		if (m > lim * lim) begin
			s = int_sqrt(m);
			x = div_round(x * lim, s);
			y = div_round(y * lim, s);
		end
	endtask

	function automatic longint abs_l(longint x);
		return (x < 0) ? -x : x;
	endfunction

	function automatic int pending();
		return exp_wr - exp_rd;
	endfunction

	task automatic reset_camera();
		img_w = 2560; crop_w = 1280; crop_h = 736;
		band_t = 205; band_b = 1085; delay = 60;
		cam_x = img_w * 128;
		cam_y = (band_t + band_b) * 128;
		vel_x = 0; vel_y = 0;
		aim_x = cam_x; aim_y = cam_y;
		avel_x = 0; avel_y = 0;
		paim_x = cam_x; paim_y = cam_y;
		idle_cnt = 0;
	endtask

	task automatic follow_frame(input frame_t f, output window_t w);
		longint dx, dy, fx, fy, left, top, nx, ny, lox, hix, loy, hiy;
		dx = aim_x - cam_x;
		dy = aim_y - cam_y;
		if (5 * abs_l(dx) < crop_w * 256 && 5 * abs_l(dy) < crop_h * 256) begin
			vel_x = div_round(3 * vel_x, 4);
			vel_y = div_round(3 * vel_y, 4);
		end else begin
			fx = div_round(dx - 25 * vel_x, 50);
			fy = div_round(dy - 25 * vel_y, 50);
			limit_vector(fx, fy, 384);
			vel_x += fx;
			vel_y += fy;
		end
		limit_vector(vel_x, vel_y, 20 * 256);
		vel_x = sat_w(vel_x, VEL_W);
		vel_y = sat_w(vel_y, VEL_W);
		lox = crop_w * 128;
		hix = img_w * 256 - crop_w * 128;
		loy = band_t * 256 + crop_h * 128;
		hiy = band_b * 256 - crop_h * 128;
		cam_x = sat_w(clip(cam_x + vel_x, lox, hix), POS_W);
		cam_y = sat_w(clip(cam_y + vel_y, loy, hiy), POS_W);

		left = (cam_x - crop_w * 128) / 256;
		top = (cam_y - crop_h * 128) / 256;
		if (left < 0) left = 0;
		if (left + crop_w > img_w) left = img_w - crop_w;
		if (top < band_t) top = band_t;
		if (top + crop_h > band_b) top = band_b - crop_h;
		w.left = COORD_BITS'(clip(left, 0, 4095));
		w.top = COORD_BITS'(clip(top, 0, 4095));

		if (f.present) begin
			nx = (longint'(f.xmin) + longint'(f.xmax)) * 128;
			ny = (longint'(f.ymin) + longint'(f.ymax)) * 128;
			avel_x = sat_w(div_round(nx - paim_x + 3 * avel_x, 4), POS_W);
			avel_y = sat_w(div_round(ny - paim_y + 3 * avel_y, 4), POS_W);
			paim_x = aim_x;
			paim_y = aim_y;
			aim_x = sat_w(clip(nx + 2 * avel_x, lox, hix), POS_W);
			aim_y = sat_w(clip(ny + 2 * avel_y, loy, hiy), POS_W);
			idle_cnt = 0;
		end
		if (!f.ball) begin
			if (idle_cnt < 65535) idle_cnt++;
			if (idle_cnt > delay) begin
				aim_x = sat_w(aim_x + div_round(img_w * 128 - aim_x, 100), POS_W);
				aim_y = sat_w(aim_y + div_round((band_t + band_b) * 128 - aim_y, 100), POS_W);
			end
		end
	endtask

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	task automatic write_reg(logic [4:0] addr, logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			REG_IMAGE_WIDTH:    img_w = data & 32'h1FFF;
			REG_CROP_WIDTH:     crop_w = data & 32'h1FFF;
			REG_CROP_HEIGHT:    crop_h = data & 32'h1FFF;
			REG_BAND_TOP:       band_t = data & 32'hFFF;
			REG_BAND_BOTTOM:    band_b = data & 32'h1FFF;
			REG_RECENTER_DELAY: delay = data & 32'hFFFF;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic send_frame(frame_t f, bit fixed, window_t want);
		window_t w;
		while ($urandom_range(99) < snd_idle) begin
			trk_if.valid <= 1'b0;
			@(posedge clk);
		end
		trk_if.valid <= 1'b1;
		trk_if.track_present <= f.present;
		trk_if.box_xmin <= f.xmin;
		trk_if.box_ymin <= f.ymin;
		trk_if.box_xmax <= f.xmax;
		trk_if.box_ymax <= f.ymax;
		trk_if.ball_seen <= f.ball;
		@(posedge clk);
		while (!trk_if.ready) @(posedge clk);
		follow_frame(f, w);
		exp_windows[exp_wr % EXP_DEPTH] = fixed ? want : w;
		exp_wr++;
	endtask

	function automatic logic signed [BOX_W-1:0] any_coord();
		return BOX_W'(longint'($urandom_range(12287)) - 4096);
	endfunction

	function automatic logic signed [BOX_W-1:0] near(longint c, int span);
		return BOX_W'(c + longint'($urandom_range(2 * span)) - span);
	endfunction

	task automatic make_frame(output frame_t f);
		int hw, hh;
		if ($urandom_range(99) < 15) begin
			f.present = $urandom_range(1);
			f.xmin = any_coord();
			f.ymin = any_coord();
			f.xmax = any_coord();
			f.ymax = any_coord();
			f.ball = $urandom_range(1);
			return;
		end
		if ($urandom_range(19) == 0) begin
			tgt_x = $urandom_range(img_w);
			tgt_y = $urandom_range(4095);
		end else begin
			tgt_x = clip(tgt_x + $urandom_range(80) - 40, 0, img_w);
			tgt_y = clip(tgt_y + $urandom_range(60) - 30, 0, 4095);
		end
		hw = $urandom_range(4, 200);
		hh = $urandom_range(4, 200);
		f.present = ($urandom_range(9) < 8);
		f.xmin = near(tgt_x - hw, 4);
		f.xmax = near(tgt_x + hw, 4);
		f.ymin = near(tgt_y - hh, 4);
		f.ymax = near(tgt_y + hh, 4);
		if (no_ball_run > 0) begin
			no_ball_run--;
			f.ball = 1'b0;
			if ($urandom_range(3) != 0) f.present = 1'b0;
		end else begin
			f.ball = 1'b1;
			if ($urandom_range(29) == 0) no_ball_run = $urandom_range(1, 40);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_if.ready <= 1'b0;
		end else begin
			win_if.ready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	always @(posedge clk) begin
		window_t want;
		cycles++;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && win_if.valid && win_if.ready) begin
			if (pending() == 0) begin
				report_mismatch("unexpected transfer", 1, 0);
			end else begin
				want = exp_windows[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (win_if.window_left !== want.left)
					report_mismatch("window_left", win_if.window_left, want.left);
				if (win_if.window_top !== want.top)
					report_mismatch("window_top", win_if.window_top, want.top);
			end
		end
	end

	initial begin
		frame_row_t rows[N_ROWS];
		frame_t     f;
		window_t    want;
		int         cfg[N_PHASES][6];
		int         idles[N_PHASES][2];

		cfg = '{'{2560, 1280, 736, 205, 1085, 60},
			'{64, 16, 16, 0, 1, 0},
			'{4096, 4096, 4096, 4095, 4096, 65535},
			'{1920, 640, 360, 100, 1000, 3},
			'{640, 1280, 480, 50, 400, 10},
			'{3000, 800, 600, 0, 2000, 20}};
		idles = '{'{27, 27}, '{51, 0}, '{0, 51}, '{0, 0}, '{27, 27}, '{51, 0}};

		errors = 0;
		cycles = 0;
		exp_wr = 0;
		exp_rd = 0;
		snd_idle = 0;
		rcv_stall = 0;
		no_ball_run = 0;
		reset_camera();
		tgt_x = 1280;
		tgt_y = 645;

		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		trk_if.valid = 1'b0;
		trk_if.track_present = 1'b0;
		trk_if.box_xmin = '0; trk_if.box_ymin = '0;
		trk_if.box_xmax = '0; trk_if.box_ymax = '0;
		trk_if.ball_seen = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: first frame after reset holds the centered window
		rows[0] = '{'{1'b0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 1'b1}, 1'b1, 12'd640, 12'd277};
		rows[1] = '{'{1'b1, -14'sd4096, -14'sd4096, -14'sd4096, -14'sd4096, 1'b1}, 1'b0, 0, 0};
		rows[2] = '{'{1'b1, 14'sd8191, 14'sd8191, 14'sd8191, 14'sd8191, 1'b1}, 1'b0, 0, 0};
		rows[3] = '{'{1'b1, -14'sd4096, 14'sd8191, 14'sd8191, -14'sd4096, 1'b0}, 1'b0, 0, 0};
		rows[4] = '{'{1'b1, 14'sd0, 14'sd205, 14'sd40, 14'sd245, 1'b1}, 1'b0, 0, 0};
		rows[5] = '{'{1'b0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 1'b1}, 1'b0, 0, 0};
		rows[6] = '{'{1'b0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 1'b0}, 1'b0, 0, 0};
		rows[7] = '{'{1'b1, 14'sd2500, 14'sd1000, 14'sd2560, 14'sd1085, 1'b1}, 1'b0, 0, 0};
		rows[8] = '{'{1'b1, 14'sd2500, 14'sd1000, 14'sd2560, 14'sd1085, 1'b0}, 1'b0, 0, 0};
		rows[9] = '{'{1'b1, 14'sd1260, 14'sd630, 14'sd1300, 14'sd660, 1'b1}, 1'b0, 0, 0};
		rows[10] = '{'{1'b1, 14'sd5461, -14'sd2731, 14'sd2730, 14'sd5461, 1'b1}, 1'b0, 0, 0};
		rows[11] = '{'{1'b1, -14'sd1, -14'sd1, 14'sd0, 14'sd0, 1'b0}, 1'b0, 0, 0};
		for (int k = 12; k < N_ROWS; k++)
			rows[k] = '{'{1'b0, 14'sd0, 14'sd0, 14'sd0, 14'sd0, 1'b1}, 1'b0, 0, 0};
		foreach (rows[i]) send_frame(rows[i].frame, rows[i].fixed, '{rows[i].left, rows[i].top});
		trk_if.valid <= 1'b0;
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			write_reg(REG_IMAGE_WIDTH, cfg[p][0]);
			write_reg(REG_CROP_WIDTH, cfg[p][1]);
			write_reg(REG_CROP_HEIGHT, cfg[p][2]);
			write_reg(REG_BAND_TOP, cfg[p][3]);
			write_reg(REG_BAND_BOTTOM, cfg[p][4]);
			write_reg(REG_RECENTER_DELAY, cfg[p][5]);
			snd_idle = idles[p][0];
			rcv_stall = idles[p][1];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				make_frame(f);
				send_frame(f, 1'b0, want);
				if (n == PHASE_ITEMS / 2 && p == 1) begin
					// hold off until all windows are back
					trk_if.valid <= 1'b0;
					while (pending() != 0) @(posedge clk);
				end
			end
			trk_if.valid <= 1'b0;
			wait_drained();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
